FILE: hw/rtl/acv_pkg.sv
// Shared constants, widths and the arctangent table for the anomaly converter.
// No dependencies; every other file of the block imports this package.
package acv_pkg;

  localparam int ACV_ANGLE_BITS = 32;   // default angle width of the ports' scale
  localparam int CORDIC_STEPS   = 30;
  localparam int DIV_STEPS      = 30;
  localparam int SQRT_STEPS     = 31;
  localparam int CW             = 34;   // CORDIC datapath width, signed
  localparam int DW             = 64;   // divider remainder and divisor width
  localparam int SW             = 62;   // square root working width

  localparam logic signed [CW-1:0] ONE_Q30  = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF_TRN = CW'(64'sd2147483648);
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(64'sd652032874);

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458908;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/anomaly_converter_core.sv
// Anomaly converter top level: eccentric <-> true anomaly, one word per cycle while the output is not stalled.
// Depends on acv_pkg, acv_cordic_cell, acv_div_cell and acv_sqrt_cell.
//
// Usage:
//  - Input channel in_valid_i/in_ready_o carries op_i (1: eccentric to true,
//    0: true to eccentric) and angle_in_i, a binary angle of 2^ANGLE_BITS per turn.
//  - Output channel out_valid_o/out_ready_i carries angle_out_o in the same scale.
//  - ecc_we_i/ecc_wdata_i writes the eccentricity (Q0.32); write it only while
//    the pipeline is empty.
//  - The pipeline is a cosine CORDIC (30 cells), restoring divider
//    (30 cells), square root (31 cells), arctangent CORDIC (30 cells) plus
//    nine single stages for setup, multiplies, adds and the output register.
//  - Throughput is one word per cycle unless the output stalls; every cell
//    moves its word on each enabled cycle.
//  - When the receiver stalls with a word in the output register, the whole
//    pipeline holds and in_ready_o drops in the same cycle.
//  - Reset clears all valid bits and sets the eccentricity to zero.
module anomaly_converter_core #(
  parameter int ANGLE_BITS = acv_pkg::ACV_ANGLE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ecc_we_i,
  input  logic [31:0] ecc_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [31:0] angle_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] angle_out_o
);
  import acv_pkg::*;

  localparam int AB  = ANGLE_BITS;
  localparam int WB  = (AB > 32) ? AB : 32;
  localparam int SHR = (AB >= 32) ? AB - 32 : 0;
  localparam int SHL = (AB < 32) ? 32 - AB : 0;
  localparam logic [WB-1:0] AMASK = {WB{1'b1}} >> (WB - AB);
  localparam logic [WB-1:0] AHALF = WB'(1) << (AB - 1);

  logic en;
  logic [31:0] ecc_q;

  // pipeline advances unless the output word is stuck
  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  // eccentricity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecc_q <= '0;
    end else if (ecc_we_i) begin
      ecc_q <= ecc_wdata_i;
    end
  end

  // ---------------- input setup: angle scaling and quadrant fold
  logic [WB-1:0]        a_w;
  logic [31:0]          t32;
  logic                 mir_in, flip_in;
  logic signed [CW-1:0] z_in;
  logic                 p_v_q;
  logic signed [CW-1:0] p_z_q;
  logic [2:0]           p_side_q;

  always_comb begin
    a_w     = WB'(angle_in_i) & AMASK;
    t32     = 32'((a_w >> SHR) << SHL);
    mir_in  = a_w > AHALF;
    z_in    = signed'({{(CW-32){t32[31]}}, t32});
    flip_in = 1'b0;
    if (z_in > ONE_Q30) begin
      z_in    = z_in - HALF_TRN;
      flip_in = 1'b1;
    end else if (z_in < -ONE_Q30) begin
      z_in    = z_in + HALF_TRN;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_z_q    <= z_in;
      p_side_q <= {op_i, mir_in, flip_in};
    end
  end

  // ---------------- cosine CORDIC chain, side = {op, mirror, flip}
  logic                 cv [0:CORDIC_STEPS];
  logic signed [CW-1:0] cx [0:CORDIC_STEPS];
  logic signed [CW-1:0] cyv[0:CORDIC_STEPS];
  logic signed [CW-1:0] cz [0:CORDIC_STEPS];
  logic [2:0]           cs [0:CORDIC_STEPS];

  assign cv[0]  = p_v_q;
  assign cx[0]  = GAIN_Q30;
  assign cyv[0] = '0;
  assign cz[0]  = p_z_q;
  assign cs[0]  = p_side_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cos
    acv_cordic_cell #(.STEP(i), .VECTOR(1'b0), .SIDE_W(3)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(cv[i]), .x_i(cx[i]), .y_i(cyv[i]), .z_i(cz[i]), .side_i(cs[i]),
      .valid_o(cv[i+1]), .x_o(cx[i+1]), .y_o(cyv[i+1]), .z_o(cz[i+1]),
      .side_o(cs[i+1])
    );
  end

  // ---------------- cosine sign restore and clamp
  logic signed [CW-1:0] cneg;
  logic signed [31:0]   c_d;
  logic                 c_v_q;
  logic signed [31:0]   c_q;
  logic [1:0]           c_side_q;

  always_comb begin
    cneg = cs[CORDIC_STEPS][0] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    if (cneg > ONE_Q30) begin
      c_d = 32'(ONE_Q30);
    end else if (cneg < -ONE_Q30) begin
      c_d = 32'(-ONE_Q30);
    end else begin
      c_d = 32'(cneg);
    end
  end

  // ---------------- e * cos x product
  logic                 m_v_q;
  logic signed [64:0]   prod;
  logic signed [63:0]   m_ce_q;
  logic signed [31:0]   m_c_q;
  logic [1:0]           m_side_q;

  assign prod = 65'(signed'(c_q)) * signed'({33'd0, ecc_q});

  // ---------------- numerator and denominator, Q61
  logic signed [63:0] c_sh, e_sh, num_d, den_d;
  logic               n_v_q, n_mir_q;
  logic signed [63:0] n_num_q, n_den_q;

  always_comb begin
    c_sh = 64'(signed'(m_c_q)) <<< 31;
    e_sh = signed'({3'd0, ecc_q, 29'd0});
    if (m_side_q[1]) begin
      num_d = c_sh - e_sh;
      den_d = (64'sd1 <<< 61) - (m_ce_q >>> 1);
    end else begin
      num_d = c_sh + e_sh;
      den_d = (64'sd1 <<< 61) + (m_ce_q >>> 1);
    end
  end

  // ---------------- magnitude and saturation check
  logic [DW-1:0] mag_num;
  logic          a_v_q, a_sat_q, a_neg_q, a_mir_q;
  logic [DW-1:0] a_r_q, a_d_q;

  assign mag_num = n_num_q[63] ? DW'(-n_num_q) : DW'(n_num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      m_v_q <= 1'b0;
      n_v_q <= 1'b0;
      a_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= cv[CORDIC_STEPS];
      m_v_q <= c_v_q;
      n_v_q <= m_v_q;
      a_v_q <= n_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q      <= c_d;
      c_side_q <= cs[CORDIC_STEPS][2:1];
      m_ce_q   <= 64'(prod);
      m_c_q    <= c_q;
      m_side_q <= c_side_q;
      n_num_q  <= num_d;
      n_den_q  <= den_d;
      n_mir_q  <= m_side_q[0];
      a_r_q    <= mag_num;
      a_d_q    <= DW'(n_den_q);
      a_sat_q  <= mag_num >= DW'(n_den_q);
      a_neg_q  <= n_num_q[63];
      a_mir_q  <= n_mir_q;
    end
  end

  // ---------------- divider chain, side = {mirror, neg, sat}
  logic          dv [0:DIV_STEPS];
  logic [DW-1:0] dr [0:DIV_STEPS];
  logic [DW-1:0] dd [0:DIV_STEPS];
  logic [29:0]   dq [0:DIV_STEPS];
  logic [2:0]    ds [0:DIV_STEPS];

  assign dv[0] = a_v_q;
  assign dr[0] = a_r_q;
  assign dd[0] = a_d_q;
  assign dq[0] = '0;
  assign ds[0] = {a_mir_q, a_neg_q, a_sat_q};

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    acv_div_cell #(.QW(30), .SIDE_W(3)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv[i]), .r_i(dr[i]), .d_i(dd[i]), .q_i(dq[i]), .side_i(ds[i]),
      .valid_o(dv[i+1]), .r_o(dr[i+1]), .d_o(dd[i+1]), .q_o(dq[i+1]),
      .side_o(ds[i+1])
    );
  end

  // ---------------- signed quotient cos y, Q30
  logic [31:0]        qmag;
  logic               q_v_q, q_mir_q;
  logic signed [31:0] q_cy_q;

  assign qmag = ds[DIV_STEPS][0] ? 32'd1073741824 : {2'b00, dq[DIV_STEPS]};

  // ---------------- cos^2 y
  logic               s_v_q, s_mir_q;
  logic signed [31:0] s_cy_q;
  logic [63:0]        s_sq_q;
  logic [60:0]        rad;

  assign rad = 61'(61'd1 << 60) - s_sq_q[60:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else if (en) begin
      q_v_q <= dv[DIV_STEPS];
      s_v_q <= q_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_cy_q  <= ds[DIV_STEPS][1] ? -signed'(qmag) : signed'(qmag);
      q_mir_q <= ds[DIV_STEPS][2];
      s_sq_q  <= 64'(q_cy_q) * 64'(q_cy_q);
      s_cy_q  <= q_cy_q;
      s_mir_q <= q_mir_q;
    end
  end

  // ---------------- square root chain, side = {mirror, cos y}
  logic          qv [0:SQRT_STEPS];
  logic [SW-1:0] qvv[0:SQRT_STEPS];
  logic [SW-1:0] qr [0:SQRT_STEPS];
  logic [32:0]   qs [0:SQRT_STEPS];

  assign qv[0]  = s_v_q;
  assign qvv[0] = SW'(rad);
  assign qr[0]  = '0;
  assign qs[0]  = {s_mir_q, s_cy_q};

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    acv_sqrt_cell #(.BIT_POS(60 - 2 * i), .SIDE_W(33)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(qv[i]), .v_i(qvv[i]), .res_i(qr[i]), .side_i(qs[i]),
      .valid_o(qv[i+1]), .v_o(qvv[i+1]), .res_o(qr[i+1]), .side_o(qs[i+1])
    );
  end

  // ---------------- vectoring setup: fold negative cosine into second quadrant
  logic signed [CW-1:0] vv, vs;
  logic                 v_v_q;
  logic signed [CW-1:0] v_x_q, v_y_q, v_z_q;
  logic                 v_mir_q;

  always_comb begin
    vv = CW'(signed'(qs[SQRT_STEPS][31:0]));
    vs = signed'(CW'(qr[SQRT_STEPS][31:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_v_q <= 1'b0;
    end else if (en) begin
      v_v_q <= qv[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_x_q   <= vv[CW-1] ? vs : vv;
      v_y_q   <= vv[CW-1] ? -vv : vs;
      v_z_q   <= vv[CW-1] ? ONE_Q30 : '0;
      v_mir_q <= qs[SQRT_STEPS][32];
    end
  end

  // ---------------- arccosine CORDIC chain, side = mirror
  logic                 av [0:CORDIC_STEPS];
  logic signed [CW-1:0] ax [0:CORDIC_STEPS];
  logic signed [CW-1:0] ay [0:CORDIC_STEPS];
  logic signed [CW-1:0] az [0:CORDIC_STEPS];
  logic [0:0]           as_[0:CORDIC_STEPS];

  assign av[0]  = v_v_q;
  assign ax[0]  = v_x_q;
  assign ay[0]  = v_y_q;
  assign az[0]  = v_z_q;
  assign as_[0] = v_mir_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_acos
    acv_cordic_cell #(.STEP(i), .VECTOR(1'b1), .SIDE_W(1)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(av[i]), .x_i(ax[i]), .y_i(ay[i]), .z_i(az[i]), .side_i(as_[i]),
      .valid_o(av[i+1]), .x_o(ax[i+1]), .y_o(ay[i+1]), .z_o(az[i+1]),
      .side_o(as_[i+1])
    );
  end

  // ---------------- clamp, rescale, mirror, output register
  logic signed [CW-1:0] zf;
  logic [31:0]          y32;
  logic [WB-1:0]        ya, res;
  logic                 out_v_q;
  logic [31:0]          out_q;

  always_comb begin
    zf = az[CORDIC_STEPS];
    if (zf[CW-1]) begin
      y32 = '0;
    end else if (zf > HALF_TRN) begin
      y32 = 32'(HALF_TRN);
    end else begin
      y32 = 32'(zf);
    end
    ya  = (WB'(y32) << SHR) >> SHL;
    res = as_[CORDIC_STEPS][0] ? ((-ya) & AMASK) : (ya & AMASK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= av[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= 32'(res);
    end
  end

  assign out_valid_o = out_v_q;
  assign angle_out_o = out_q;

endmodule

FILE: hw/rtl/acv_cordic_cell.sv
// One CORDIC micro-rotation stage, rotation or vectoring mode, with sideband.
// Depends on acv_pkg for widths and the arctangent table.
module acv_cordic_cell #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0,
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [acv_pkg::CW-1:0] x_i,
  input  logic signed [acv_pkg::CW-1:0] y_i,
  input  logic signed [acv_pkg::CW-1:0] z_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic signed [acv_pkg::CW-1:0] x_o,
  output logic signed [acv_pkg::CW-1:0] y_o,
  output logic signed [acv_pkg::CW-1:0] z_o,
  output logic [SIDE_W-1:0]           side_o
);
  import acv_pkg::*;

  localparam logic signed [CW-1:0] ATAN = signed'({2'b00, atan_turn(STEP)});

  logic signed [CW-1:0] dx, dy, x_d, y_d, z_d;
  logic                 pos;

  // direction: sign of residual angle, or of y when vectoring
  always_comb begin
    dx  = y_i >>> STEP;
    dy  = x_i >>> STEP;
    pos = VECTOR ? y_i[CW-1] : ~z_i[CW-1];
    if (pos) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      side_o <= side_i;
    end
  end

endmodule

FILE: hw/rtl/acv_div_cell.sv
// One restoring division step: shift remainder, compare, subtract, shift in bit.
// Depends on acv_pkg for the datapath width.
module acv_div_cell #(
  parameter int QW     = 30,
  parameter int SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [acv_pkg::DW-1:0]    r_i,
  input  logic [acv_pkg::DW-1:0]    d_i,
  input  logic [QW-1:0]             q_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [acv_pkg::DW-1:0]    r_o,
  output logic [acv_pkg::DW-1:0]    d_o,
  output logic [QW-1:0]             q_o,
  output logic [SIDE_W-1:0]         side_o
);
  import acv_pkg::*;

  logic [DW-1:0] r2;
  logic          ge;

  // a remainder that enters below the divisor stays below it, so the shift never overflows
  always_comb begin
    r2 = {r_i[DW-2:0], 1'b0};
    ge = r2 >= d_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o    <= ge ? r2 - d_i : r2;
      d_o    <= d_i;
      q_o    <= {q_i[QW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

FILE: hw/rtl/acv_sqrt_cell.sv
// One step of the bitwise integer square root at a fixed trial bit.
// Depends on acv_pkg for the datapath width.
module acv_sqrt_cell #(
  parameter int BIT_POS = 60,
  parameter int SIDE_W  = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [acv_pkg::SW-1:0] v_i,
  input  logic [acv_pkg::SW-1:0] res_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [acv_pkg::SW-1:0] v_o,
  output logic [acv_pkg::SW-1:0] res_o,
  output logic [SIDE_W-1:0]      side_o
);
  import acv_pkg::*;

  localparam logic [SW-1:0] TBIT = SW'(1) << BIT_POS;

  logic [SW-1:0] trial;
  logic          ge;

  always_comb begin
    trial = res_i + TBIT;
    ge    = v_i >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o    <= ge ? v_i - trial : v_i;
      res_o  <= ge ? (res_i >> 1) + TBIT : res_i >> 1;
      side_o <= side_i;
    end
  end

endmodule
